// ----- rtl/ses_pkg.sv -----
// Package for the encoder setpoint editor.
// Holds the word types, configuration types, phase encoding and reset constants.
`timescale 1ns / 1ps

package ses_pkg;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;
    localparam int CountWidth    = 16;
    localparam int ValueWidth    = 8;

    localparam logic [CountWidth-1:0] HoldTicksReset    = 16'd1000;
    localparam logic [CountWidth-1:0] ReleaseTicksReset = 16'd100;
    localparam logic [ValueWidth-1:0] MaxSetpointReset  = 8'd100;
    localparam logic [ValueWidth-1:0] SetpointReset     = 8'd50;

    localparam logic [CfgIndexWidth-1:0] CFG_HOLD_TICKS    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_RELEASE_TICKS = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_SETPOINT  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_WAIT_ENTER  = 2'd1,
        PH_EDIT        = 2'd2,
        PH_WAIT_COMMIT = 2'd3
    } t_phase;

    typedef struct packed {
        logic button_level;
        logic enc_clock;
        logic enc_data;
    } t_in_word;

    typedef struct packed {
        logic [ValueWidth-1:0] setpoint_out;
        logic [ValueWidth-1:0] edit_out;
        logic                  editing;
    } t_out_word;

    typedef struct packed {
        logic [CountWidth-1:0] hold_ticks;
        logic [CountWidth-1:0] release_ticks;
        logic [ValueWidth-1:0] max_setpoint;
    } t_cfg;

endpackage

// ----- rtl/ses_core.sv -----
// Phase sequencer and edit datapath of the encoder setpoint editor.
// Depends on ses_pkg; updates its state once for every accepted word.
`timescale 1ns / 1ps

module ses_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ses_pkg::t_in_word  i_in_word,
    input  ses_pkg::t_cfg      i_cfg,
    output ses_pkg::t_out_word o_next_word
);
    import ses_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [CountWidth-1:0] r_tick_count;
    logic [CountWidth-1:0] n_tick_count;
    logic                  r_last_clock;
    logic                  n_last_clock;
    logic [ValueWidth-1:0] r_edit_value;
    logic [ValueWidth-1:0] n_edit_value;
    logic [ValueWidth-1:0] r_setpoint;
    logic [ValueWidth-1:0] n_setpoint;

    logic                  pressed;
    logic                  at_level;
    logic [CountWidth-1:0] limit;
    logic [CountWidth-1:0] count_inc;
    logic                  limit_met;

    assign pressed = ~i_in_word.button_level;

    always_comb begin
        unique case (r_phase) inside
            PH_IDLE, PH_EDIT: begin
                at_level = pressed;
                limit    = i_cfg.hold_ticks;
            end
            default: begin
                at_level = ~pressed;
                limit    = i_cfg.release_ticks;
            end
        endcase
    end

    assign count_inc = (&r_tick_count) ? r_tick_count : r_tick_count + 1'b1;
    assign limit_met = at_level && (count_inc >= limit);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (limit_met) n_phase = PH_WAIT_ENTER;
            end
            PH_WAIT_ENTER: begin
                if (limit_met) n_phase = PH_EDIT;
            end
            PH_EDIT: begin
                if (limit_met) n_phase = PH_WAIT_COMMIT;
            end
            PH_WAIT_COMMIT: begin
                if (limit_met) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_comb begin
        n_last_clock = r_last_clock;
        n_edit_value = r_edit_value;
        n_setpoint   = r_setpoint;
        if (!at_level || limit_met) begin
            n_tick_count = '0;
        end else begin
            n_tick_count = count_inc;
        end
        unique case (r_phase)
            PH_WAIT_ENTER: begin
                if (limit_met) begin
                    n_last_clock = i_in_word.enc_clock;
                    n_edit_value = r_setpoint;
                end
            end
            PH_EDIT: begin
                if (i_in_word.enc_clock != r_last_clock) begin
                    n_last_clock = i_in_word.enc_clock;
                    if (i_in_word.enc_clock ^ i_in_word.enc_data) begin
                        if (r_edit_value >= i_cfg.max_setpoint) begin
                            n_edit_value = i_cfg.max_setpoint;
                        end else begin
                            n_edit_value = r_edit_value + 1'b1;
                        end
                    end else if (r_edit_value != '0) begin
                        n_edit_value = r_edit_value - 1'b1;
                    end
                end
            end
            PH_WAIT_COMMIT: begin
                if (limit_met) n_setpoint = r_edit_value;
            end
            default: begin
            end
        endcase
    end

    assign o_next_word.setpoint_out = n_setpoint;
    assign o_next_word.edit_out     = n_edit_value;
    assign o_next_word.editing      = (n_phase == PH_EDIT) || (n_phase == PH_WAIT_COMMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_last_clock <= 1'b0;
            r_edit_value <= '0;
            r_setpoint   <= SetpointReset;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_last_clock <= n_last_clock;
            r_edit_value <= n_edit_value;
            r_setpoint   <= n_setpoint;
        end
    end

endmodule

// ----- rtl/encoder_setpoint_editor_top.sv -----
// Top level of the encoder setpoint editor.
// Depends on ses_pkg and ses_core; holds the configuration registers and output register.
`timescale 1ns / 1ps

// The input channel carries one word per millisecond tick with the sampled
// button, encoder clock and encoder data levels. Every accepted word yields
// exactly one output word with the committed setpoint, the edit value and
// the edit mode flag as they stand after that tick.
// The result word is valid in the cycle after its input word is accepted.
// The block takes one word per cycle while the receiver does not stall the output,
// set by the single state update in the core and the one output register.
// The input stalls only when the output register is full and the receiver
// stalls it; a word taken in the same cycle frees room for the next one.
// The configuration port writes hold_ticks, release_ticks and max_setpoint by
// index and should be used only while no word is in flight.
// Synchronous reset returns the block to idle with setpoint 50, edit value 0,
// the default configuration and an empty output register.
module encoder_setpoint_editor_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ses_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ses_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_we,
    input  logic [ses_pkg::CfgIndexWidth-1:0]   i_cfg_index,
    input  logic [ses_pkg::CfgDataWidth-1:0]    i_cfg_data
);
    import ses_pkg::*;

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word next_word;
    logic      in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    ses_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_in_word   (i_in_word),
        .i_cfg       (r_cfg),
        .o_next_word (next_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks    <= HoldTicksReset;
            r_cfg.release_ticks <= ReleaseTicksReset;
            r_cfg.max_setpoint  <= MaxSetpointReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_data;
                CFG_RELEASE_TICKS: r_cfg.release_ticks <= i_cfg_data;
                CFG_MAX_SETPOINT:  r_cfg.max_setpoint  <= i_cfg_data[ValueWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_word <= next_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- bench/encoder_setpoint_editor_top_test.sv -----
// Self-checking testbench for encoder_setpoint_editor_top.
// Drives button and encoder ticks, predicts each output word and compares it.
// Depends on ses_pkg and the encoder_setpoint_editor_top RTL.
`timescale 1ns / 1ps

module encoder_setpoint_editor_top_test;
    import ses_pkg::*;

    localparam int CycleLimit = 1_000_000;
    localparam int IdlePercent = 18;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_word                 i_in_word = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_word                o_out_word;
    logic                     i_cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] i_cfg_index = CFG_HOLD_TICKS;
    logic [CfgDataWidth-1:0]  i_cfg_data = '0;

    t_in_word  tick_queue[$];
    t_out_word predicted_status[$];
    bit        no_idle = 1'b0;
    int        error_count = 0;
    int        cycle_count = 0;
    int        gen_count = 0;
    bit        gen_clock = 1'b0;

    t_cfg                  cfg_now;
    t_phase                ed_phase;
    logic [CountWidth-1:0] run_len;
    logic                  seen_clock;
    logic [ValueWidth-1:0] edit_val;
    logic [ValueWidth-1:0] setpt;

    encoder_setpoint_editor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function bit count_run(bit at_level, logic [CountWidth-1:0] limit);
        if (!at_level) begin
            run_len = '0;
            return 1'b0;
        end
        if (run_len != '1) begin
            run_len = run_len + 1'b1;
        end
        if (run_len >= limit) begin
            run_len = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function t_out_word step_editor(t_in_word w);
        bit        pressed;
        t_out_word r;
        pressed = !w.button_level;
        case (ed_phase)
            PH_IDLE: begin
                if (count_run(pressed, cfg_now.hold_ticks)) begin
                    ed_phase = PH_WAIT_ENTER;
                end
            end
            PH_WAIT_ENTER: begin
                if (count_run(!pressed, cfg_now.release_ticks)) begin
                    seen_clock = w.enc_clock;
                    edit_val = setpt;
                    ed_phase = PH_EDIT;
                end
            end
            PH_EDIT: begin
                if (w.enc_clock != seen_clock) begin
                    seen_clock = w.enc_clock;
                    if (w.enc_clock ^ w.enc_data) begin
                        if (edit_val >= cfg_now.max_setpoint) begin
                            edit_val = cfg_now.max_setpoint;
                        end else begin
                            edit_val = edit_val + 1'b1;
                        end
                    end else if (edit_val != '0) begin
                        edit_val = edit_val - 1'b1;
                    end
                end
                if (count_run(pressed, cfg_now.hold_ticks)) begin
                    ed_phase = PH_WAIT_COMMIT;
                end
            end
            default: begin
                if (count_run(!pressed, cfg_now.release_ticks)) begin
                    setpt = edit_val;
                    ed_phase = PH_IDLE;
                end
            end
        endcase
        r.setpoint_out = setpt;
        r.edit_out = edit_val;
        r.editing = (ed_phase == PH_EDIT) || (ed_phase == PH_WAIT_COMMIT);
        return r;
    endfunction

    task flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    // Driver: takes the next tick from the queue once the current word is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_status.push_back(step_editor(i_in_word));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tick_queue.size() > 0 &&
                    (no_idle || $urandom_range(0, 99) >= IdlePercent)) begin
                    i_in_valid <= 1'b1;
                    i_in_word <= tick_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken output word against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (predicted_status.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("output word with no prediction waiting: %h", o_out_word);
                    end
                end else begin
                    want = predicted_status.pop_front();
                    if (o_out_word.setpoint_out !== want.setpoint_out) begin
                        flag_mismatch("setpoint_out", want.setpoint_out,
                                      o_out_word.setpoint_out);
                    end
                    if (o_out_word.edit_out !== want.edit_out) begin
                        flag_mismatch("edit_out", want.edit_out, o_out_word.edit_out);
                    end
                    if (o_out_word.editing !== want.editing) begin
                        flag_mismatch("editing", 8'(want.editing), 8'(o_out_word.editing));
                    end
                end
            end
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < IdlePercent);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("** encoder_setpoint_editor_top: FAILED **");
            $finish;
        end
    end

    task automatic push_tick(bit btn, bit clk, bit dat);
        t_in_word w;
        w.button_level = btn;
        w.enc_clock = clk;
        w.enc_data = dat;
        tick_queue.push_back(w);
        gen_clock = clk;
        gen_count++;
    endtask

    task automatic push_run(bit btn, int n, bit turning);
        bit clk;
        for (int i = 0; i < n; i++) begin
            clk = gen_clock ^ (turning & 1'($urandom_range(0, 1)));
            push_tick(btn, clk, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic push_steps(bit up, int n);
        bit clk;
        for (int i = 0; i < n; i++) begin
            clk = !gen_clock;
            push_tick(1'b1, clk, up ? !clk : clk);
        end
    endtask

    task automatic wait_quiet();
        while (tick_queue.size() != 0 || i_in_valid || predicted_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] hold, logic [15:0] rel, logic [7:0] top);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_HOLD_TICKS;
        i_cfg_data <= hold;
        cfg_now.hold_ticks = hold;
        @(posedge i_clk);
        i_cfg_index <= CFG_RELEASE_TICKS;
        i_cfg_data <= rel;
        cfg_now.release_ticks = rel;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_SETPOINT;
        i_cfg_data <= {8'd0, top};
        cfg_now.max_setpoint = top;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly complete press, release and turn gestures, with short presses
    // and fully random ticks mixed in.
    task automatic random_gestures(int count);
        int start;
        int hold;
        int rel;
        int pick;
        start = gen_count;
        hold = (cfg_now.hold_ticks == 0) ? 1 : int'(cfg_now.hold_ticks);
        rel = (cfg_now.release_ticks == 0) ? 1 : int'(cfg_now.release_ticks);
        while (gen_count - start < count) begin
            pick = $urandom_range(0, 9);
            case (pick) inside
                0, 1, 2: push_run(1'b0, hold + $urandom_range(0, 2),
                                  1'($urandom_range(0, 1)));
                3, 4: push_run(1'b1, rel + $urandom_range(0, 2),
                               1'($urandom_range(0, 1)));
                5, 6: push_run(1'b1, $urandom_range(1, 30), 1'b1);
                7: push_run(1'b0, (hold > 1) ? $urandom_range(1, hold - 1) : 1, 1'b1);
                8: push_run(1'b1, (rel > 1) ? $urandom_range(1, rel - 1) : 1, 1'b1);
                default: begin
                    repeat ($urandom_range(1, 8)) begin
                        push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    end
                end
            endcase
        end
    endtask

    initial begin : stimulus
        logic [7:0] top;
        cfg_now.hold_ticks = HoldTicksReset;
        cfg_now.release_ticks = ReleaseTicksReset;
        cfg_now.max_setpoint = MaxSetpointReset;
        ed_phase = PH_IDLE;
        run_len = '0;
        seen_clock = 1'b0;
        edit_val = '0;
        setpt = SetpointReset;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 8; i++) begin
            push_tick(i[2], i[1], i[0]);
        end
        wait_quiet();

        set_config(16'd1, 16'd3, 8'd255);
        push_tick(1'b0, 1'b0, 1'b0);
        push_run(1'b1, 3, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1);
        wait_quiet();

        // Zero counts act as one; limit 0 forces the edit value down to 0.
        set_config(16'd0, 16'd0, 8'd0);
        push_tick(1'b0, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b1);
        wait_quiet();

        no_idle = 1'b1;
        set_config(16'd100, 16'd60, 8'd200);
        push_run(1'b0, 100, 1'b1);
        push_run(1'b1, 60, 1'b0);
        push_run(1'b1, 20, 1'b1);
        wait_quiet();
        no_idle = 1'b0;

        set_config(16'd1, 16'd1, 8'd255);
        push_steps(1'b1, 260);
        push_tick(1'b0, gen_clock, 1'b0);
        push_tick(1'b1, gen_clock, 1'b0);
        push_tick(1'b0, gen_clock, 1'b0);
        push_tick(1'b1, gen_clock, 1'b0);
        push_steps(1'b0, 260);
        push_tick(1'b0, gen_clock, 1'b0);
        push_tick(1'b1, gen_clock, 1'b0);
        wait_quiet();

        for (int p = 0; p < 4; p++) begin
            top = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(40, 70));
            set_config(16'($urandom_range(1, 10)), 16'($urandom_range(1, 10)), top);
            random_gestures(150);
            wait_quiet();
            random_gestures(150);
            wait_quiet();
        end

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && predicted_status.size() == 0) begin
            $display("** encoder_setpoint_editor_top: PASSED **");
        end else begin
            $display("** encoder_setpoint_editor_top: FAILED **");
        end
        $finish;
    end

endmodule
